/* sv/restarted_greedy_change_maker_defines.svh */
// Assertion macros shared by the change maker RTL.
`ifndef RESTARTED_GREEDY_CHANGE_MAKER_DEFINES_SVH
`define RESTARTED_GREEDY_CHANGE_MAKER_DEFINES_SVH
`ifndef SYNTHESIS
`define RGCM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rgcm: property violated");
`define RGCM_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("rgcm: forbidden condition seen");
`else
`define RGCM_ASSERT(lbl, clk, rst_n, prop)
`define RGCM_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* sv/rgcm_pkg.sv */
// Types, constants and microprogram of the change maker.
`default_nettype none
package rgcm_pkg;

    localparam int W          = 16;
    localparam int NUM_REGS   = 5;
    localparam int MAX_DENOMS = 8;
    localparam int IDX_W      = 4;
    localparam int REG_IDX_W  = 3;

    typedef logic [W-1:0] t_word;

    localparam t_word DENOM_RST [NUM_REGS] = '{16'd250, 16'd120, 16'd100, 16'd50, 16'd10};

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS_INIT,
        S_CHECK,
        S_TEST,
        S_DIV,
        S_LIMIT,
        S_PASS_END,
        S_PUBLISH
    } t_step;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_INPUT,
        C_IDX_END,
        C_SKIP,
        C_DIV_BUSY,
        C_UNDER_LIMIT,
        C_FINISH,
        C_OUT_BUSY
    } t_cond;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT_PASS,
        OP_NEXT_IDX,
        OP_DIV_START,
        OP_DIV_TAKE,
        OP_ABANDON,
        OP_KEEP,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_cond cond;
        t_step jmp;
        t_step nxt;
        t_op   op_j;
        t_op   op_f;
    } t_uword;

    typedef struct packed {
        logic  start;
        t_word dividend;
        t_word divisor;
    } t_div_req;

    typedef struct packed {
        logic  busy;
        t_word quo;
        t_word rem;
    } t_div_rsp;

    function automatic t_uword uprog(input t_step s);
        t_uword w;
        case (s)
            S_IDLE:      w = '{C_NO_INPUT,    S_IDLE,      S_PASS_INIT, OP_NOP,       OP_LOAD};
            S_PASS_INIT: w = '{C_ALWAYS,      S_CHECK,     S_CHECK,     OP_INIT_PASS, OP_INIT_PASS};
            S_CHECK:     w = '{C_IDX_END,     S_PASS_END,  S_TEST,      OP_NOP,       OP_NOP};
            S_TEST:      w = '{C_SKIP,        S_CHECK,     S_DIV,       OP_NEXT_IDX,  OP_DIV_START};
            S_DIV:       w = '{C_DIV_BUSY,    S_DIV,       S_LIMIT,     OP_NOP,       OP_DIV_TAKE};
            S_LIMIT:     w = '{C_UNDER_LIMIT, S_CHECK,     S_PASS_END,  OP_NEXT_IDX,  OP_ABANDON};
            S_PASS_END:  w = '{C_FINISH,      S_PUBLISH,   S_PASS_INIT, OP_KEEP,      OP_KEEP};
            S_PUBLISH:   w = '{C_OUT_BUSY,    S_PUBLISH,   S_IDLE,      OP_NOP,       OP_EMIT};
            default:     w = '{C_ALWAYS,      S_IDLE,      S_IDLE,      OP_NOP,       OP_NOP};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* sv/rgcm_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rgcm_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rgcm_pkg::t_div_req  i_req,
    output rgcm_pkg::t_div_rsp  o_rsp
);

    localparam int W     = rgcm_pkg::W;
    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_dsr;
    logic [W:0]       w_trial;

    assign w_trial = {r_acc, r_quo[W-1]} - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_quo <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            if (!w_trial[W]) begin
                r_acc <= w_trial[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_acc <= {r_acc[W-2:0], r_quo[W-1]};
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_acc;

endmodule
`default_nettype wire

/* sv/restarted_greedy_change_maker.sv */
// Top level of the restarted greedy change maker.
// Splits each amount into notes of the configured denominations by repeated
// greedy passes and returns the split with the fewest notes. One item is
// worked at a time: accept, then a pass setup, a check and a test for each
// denomination, a division on the shared restoring divider for each
// denomination that takes notes, a close for each pass (a pass is abandoned
// once its note count reaches the best so far) and a publish, which waits
// while the previous result has not been taken. A finished result waits in
// the output register while the next amount is taken in. Write the
// denominations only while no item is in flight.
`default_nettype none
`include "restarted_greedy_change_maker_defines.svh"
module restarted_greedy_change_maker #(
    parameter int NUM_DENOMS = 5
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire  [15:0]                        i_amount,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic [15:0]                        o_count_a,
    output logic [15:0]                        o_count_b,
    output logic [15:0]                        o_count_c,
    output logic [15:0]                        o_count_d,
    output logic [15:0]                        o_count_e,
    output logic [15:0]                        o_total_notes,
    input  wire                                i_cfg_wr_en,
    input  wire  [rgcm_pkg::REG_IDX_W-1:0]     i_cfg_addr,
    input  wire  [15:0]                        i_cfg_wdata
);

    localparam int IDX_W = rgcm_pkg::IDX_W;
    localparam int NREG  = rgcm_pkg::NUM_REGS;
    localparam int RIW   = rgcm_pkg::REG_IDX_W;
    localparam int N_ACT = (NUM_DENOMS > rgcm_pkg::MAX_DENOMS) ? rgcm_pkg::MAX_DENOMS
                                                               : NUM_DENOMS;
    localparam logic [IDX_W-1:0] N_LIM = IDX_W'(N_ACT);

    rgcm_pkg::t_step    r_step;
    rgcm_pkg::t_step    n_step;
    rgcm_pkg::t_uword   w_uw;
    rgcm_pkg::t_op      w_op;
    logic               w_take;

    rgcm_pkg::t_word    r_denom [NREG];
    rgcm_pkg::t_word    w_denom;

    rgcm_pkg::t_word    r_amount;
    rgcm_pkg::t_word    r_rem;
    rgcm_pkg::t_word    r_sum;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_start;
    logic [IDX_W-1:0]   r_first;
    logic               r_first_vld;
    logic               r_done;
    logic               r_have_best;
    rgcm_pkg::t_word    r_cur [NREG];
    rgcm_pkg::t_word    r_best [NREG];
    rgcm_pkg::t_word    r_best_total;

    logic               r_out_vld;
    rgcm_pkg::t_word    r_out_cnt [NREG];
    rgcm_pkg::t_word    r_out_total;

    rgcm_pkg::t_div_req w_div_req;
    rgcm_pkg::t_div_rsp w_div_rsp;

    rgcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        w_denom = '0;
        if (r_idx < IDX_W'(NREG)) begin
            w_denom = r_denom[r_idx[RIW-1:0]];
        end
    end

    // next step
    always_comb begin
        w_uw = rgcm_pkg::uprog(r_step);
        case (w_uw.cond)
            rgcm_pkg::C_ALWAYS:      w_take = 1'b1;
            rgcm_pkg::C_NO_INPUT:    w_take = !i_valid;
            rgcm_pkg::C_IDX_END:     w_take = (r_idx >= N_LIM);
            rgcm_pkg::C_SKIP:        w_take = (w_denom == '0) || (r_rem < w_denom);
            rgcm_pkg::C_DIV_BUSY:    w_take = w_div_rsp.busy;
            rgcm_pkg::C_UNDER_LIMIT: w_take = !(r_have_best && (r_best_total <= r_sum));
            rgcm_pkg::C_FINISH:      w_take = !r_first_vld ||
                                              ((r_first + IDX_W'(1)) >= N_LIM);
            rgcm_pkg::C_OUT_BUSY:    w_take = r_out_vld && !i_ready;
            default:                 w_take = 1'b1;
        endcase
        n_step = w_take ? w_uw.jmp : w_uw.nxt;
    end

    // control outputs
    always_comb begin
        w_op               = w_take ? w_uw.op_j : w_uw.op_f;
        w_div_req.start    = (w_op == rgcm_pkg::OP_DIV_START);
        w_div_req.dividend = r_rem;
        w_div_req.divisor  = w_denom;
        o_ready            = (r_step == rgcm_pkg::S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= rgcm_pkg::S_IDLE;
            r_out_vld   <= 1'b0;
            r_have_best <= 1'b0;
            for (int k = 0; k < NREG; k++) begin
                r_denom[k] <= rgcm_pkg::DENOM_RST[k];
            end
        end else begin
            r_step <= n_step;
            if (i_cfg_wr_en && (i_cfg_addr < RIW'(NREG))) begin
                r_denom[i_cfg_addr] <= i_cfg_wdata;
            end
            if (w_op == rgcm_pkg::OP_EMIT) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_op == rgcm_pkg::OP_LOAD) begin
                r_have_best <= 1'b0;
            end else if (w_op == rgcm_pkg::OP_KEEP) begin
                r_have_best <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (w_op)
            rgcm_pkg::OP_LOAD: begin
                r_amount <= i_amount;
                r_start  <= '0;
            end
            rgcm_pkg::OP_INIT_PASS: begin
                r_rem       <= r_amount;
                r_sum       <= '0;
                r_idx       <= r_start;
                r_first_vld <= 1'b0;
                r_done      <= 1'b1;
                for (int k = 0; k < NREG; k++) begin
                    r_cur[k] <= '0;
                end
            end
            rgcm_pkg::OP_NEXT_IDX: begin
                r_idx <= r_idx + IDX_W'(1);
            end
            rgcm_pkg::OP_DIV_START: begin
                if (!r_first_vld) begin
                    r_first     <= r_idx;
                    r_first_vld <= 1'b1;
                end
            end
            rgcm_pkg::OP_DIV_TAKE: begin
                if (r_idx < IDX_W'(NREG)) begin
                    r_cur[r_idx[RIW-1:0]] <= w_div_rsp.quo;
                end
                r_rem <= w_div_rsp.rem;
                r_sum <= r_sum + w_div_rsp.quo;
            end
            rgcm_pkg::OP_ABANDON: begin
                r_done <= 1'b0;
            end
            rgcm_pkg::OP_KEEP: begin
                if (!r_have_best || (r_done && r_first_vld && (r_sum < r_best_total))) begin
                    r_best       <= r_cur;
                    r_best_total <= r_sum;
                end
                r_start <= r_first + IDX_W'(1);
            end
            rgcm_pkg::OP_EMIT: begin
                r_out_cnt   <= r_best;
                r_out_total <= r_best_total;
            end
            default: begin
            end
        endcase
    end

    assign o_valid       = r_out_vld;
    assign o_count_a     = r_out_cnt[0];
    assign o_count_b     = r_out_cnt[1];
    assign o_count_c     = r_out_cnt[2];
    assign o_count_d     = r_out_cnt[3];
    assign o_count_e     = r_out_cnt[4];
    assign o_total_notes = r_out_total;

    `RGCM_NEVER(a_div_overlap, i_clk, i_rst_n, w_div_req.start && w_div_rsp.busy)
    `RGCM_ASSERT(a_sum_bound, i_clk, i_rst_n, (r_step == rgcm_pkg::S_CHECK) |-> (r_sum <= r_amount))
    `RGCM_ASSERT(a_best_bound, i_clk, i_rst_n, r_have_best |-> (r_best_total <= r_amount))
    `RGCM_ASSERT(a_accept_start, i_clk, i_rst_n, (i_valid && o_ready) |=> (r_step == rgcm_pkg::S_PASS_INIT))

endmodule
`default_nettype wire
